// ===== hdl/apru_pkg.sv =====
package apru_pkg;

    // Widths of the stream fields and of the age counters, and the age counter's top bit
    localparam int TS_W    = 16;
    localparam int PG_W    = 16;
    localparam int SLOT_W  = 3;
    localparam int AGE_W   = 8;
    localparam int AGE_TOP = 7;

    // Packed stream widths, rounded up to whole bytes
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 24;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
    } cmd_t;

endpackage

// ===== hdl/apru_ctrl.sv =====
module apru_ctrl
    import apru_pkg::*;
#(
    parameter int FRAMES = 8,
    parameter int IDX_W  = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output cmd_t             cmd,
    output logic [IDX_W-1:0] rd_addr
);

    localparam logic [IDX_W-1:0] LastIdx = IDX_W'(FRAMES - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_full_reg, out_full_next;

    // State and counter registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            out_full_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            out_full_reg <= out_full_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (idx_reg == LastIdx) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (!out_full_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs, scan counter and result register occupancy
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        idx_next = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                idx_next = '0;
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
                idx_next  = idx_reg + IDX_W'(1);
            end
            ST_WRITE: begin
                cmd.commit = !out_full_reg || m_tready;
            end
            default: begin
                cmd = '0;
            end
        endcase
        rd_addr       = idx_reg;
        m_tvalid      = out_full_reg;
        out_full_next = cmd.commit || (out_full_reg && !m_tready);
    end

endmodule

// ===== hdl/apru_dp.sv =====
module apru_dp
    import apru_pkg::*;
#(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16,
    parameter int IDX_W     = 3,
    parameter int CNT_W     = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    input  logic [IDX_W-1:0]    rd_addr,
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                full
);

    localparam logic [AGE_W-1:0] AgeMark = AGE_W'(1) << AGE_TOP;

    // Frame store: one read and one write port each
    logic [PAGE_BITS-1:0] page_mem [FRAMES];
    logic [AGE_W-1:0]     age_mem  [FRAMES];

    logic [TS_W-1:0]      last_time_reg;
    logic [CNT_W-1:0]     used_reg;
    logic                 tick_reg;
    logic [PAGE_BITS-1:0] cur_page_reg;

    logic                 proc_vld_reg;
    logic [IDX_W-1:0]     proc_idx_reg;
    logic [PAGE_BITS-1:0] rd_page_reg;
    logic [AGE_W-1:0]     rd_age_reg;

    logic                 hit_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic [AGE_W-1:0]     hit_age_reg;
    logic [IDX_W-1:0]     min_idx_reg;
    logic [AGE_W-1:0]     min_age_reg;
    logic [PAGE_BITS-1:0] min_page_reg;

    logic                 out_hit_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic [PG_W-1:0]      out_evict_reg;

    logic [TS_W-1:0]      in_ts;
    logic [PAGE_BITS-1:0] in_page;
    logic [AGE_W-1:0]     age_sh;
    logic                 proc_in_use;
    logic                 better;
    logic [IDX_W-1:0]     slot;
    logic [AGE_W-1:0]     age_new;
    logic [31:0]          slot_wide;

    assign in_ts   = s_tdata[TS_W-1:0];
    assign in_page = PAGE_BITS'(s_tdata[TS_W +: PG_W]);
    assign full    = (used_reg == CNT_W'(FRAMES));

    // Scanned entry: apply the aging shift when this access starts a new tick
    always_comb begin
        age_sh      = tick_reg ? (rd_age_reg >> 1) : rd_age_reg;
        proc_in_use = (CNT_W'(proc_idx_reg) < used_reg);
        better      = (proc_idx_reg == '0) || (age_sh < min_age_reg) ||
                      ((age_sh == min_age_reg) && (rd_page_reg < min_page_reg));
    end

    // Frame chosen for this access and its new age
    always_comb begin
        if (hit_reg) begin
            slot    = hit_idx_reg;
            age_new = hit_age_reg | AgeMark;
        end else if (!full) begin
            slot    = IDX_W'(used_reg);
            age_new = AgeMark;
        end else begin
            slot    = min_idx_reg;
            age_new = AgeMark;
        end
        slot_wide = 32'(slot);
    end

    // Memory read, registered
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_page_reg <= page_mem[rd_addr];
            rd_age_reg  <= age_mem[rd_addr];
        end
        proc_idx_reg <= rd_addr;
    end

    // Memory writes: aging write-back during the scan, frame update at commit
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            age_mem[slot] <= age_new;
            if (!hit_reg) page_mem[slot] <= cur_page_reg;
        end else if (proc_vld_reg && proc_in_use) begin
            age_mem[proc_idx_reg] <= age_sh;
        end
    end

    // Control state of the datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg <= '0;
            used_reg      <= '0;
            proc_vld_reg  <= 1'b0;
            hit_reg       <= 1'b0;
        end else begin
            proc_vld_reg <= cmd.rd_en;
            if (cmd.load) begin
                last_time_reg <= in_ts;
                hit_reg       <= 1'b0;
            end else if (proc_vld_reg && proc_in_use && !hit_reg &&
                         (rd_page_reg == cur_page_reg)) begin
                hit_reg <= 1'b1;
            end
            if (cmd.commit && !hit_reg && !full) used_reg <= used_reg + CNT_W'(1);
        end
    end

    // Item capture, hit and victim trackers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            tick_reg     <= (in_ts != last_time_reg);
            cur_page_reg <= in_page;
        end
        if (proc_vld_reg && proc_in_use && !hit_reg && (rd_page_reg == cur_page_reg)) begin
            hit_idx_reg <= proc_idx_reg;
            hit_age_reg <= age_sh;
        end
        if (proc_vld_reg && better) begin
            min_idx_reg  <= proc_idx_reg;
            min_age_reg  <= age_sh;
            min_page_reg <= rd_page_reg;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_hit_reg   <= hit_reg;
            out_slot_reg  <= slot_wide[SLOT_W-1:0];
            out_evict_reg <= (!hit_reg && full) ? PG_W'(min_page_reg) : '0;
        end
    end

    assign m_tdata = {{(M_DATA_W - 1 - SLOT_W - PG_W){1'b0}},
                      out_evict_reg, out_slot_reg, out_hit_reg};

endmodule

// ===== hdl/aging_page_replacement_unit.sv =====
// Aging page replacement unit over FRAMES frames with 8-bit age counters.
// After an item is accepted, the controller scans every frame, passes through a drain state
// and writes the result register, waiting while the previous result is still untaken. No new
// item is accepted before that write; the scan reads one frame per cycle from the frame store
// for the hit check, aging and victim search.
// Reset (aresetn low, synchronous) empties all frames and clears the last time stamp.
module aging_page_replacement_unit
    import apru_pkg::*;
#(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // time_stamp[15:0], page[31:16]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // hit[0], frame_slot[3:1], evicted_page[19:4]
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);

    cmd_t             cmd;
    logic [IDX_W-1:0] rd_addr;
    logic             full;

    apru_ctrl #(
        .FRAMES (FRAMES),
        .IDX_W  (IDX_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .rd_addr  (rd_addr)
    );

    apru_dp #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .full    (full)
    );

    // A hit never reports an evicted page.
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[19:4] == '0))
        else $error("hit result carries an evicted page");

    // A page is only evicted once every frame is in use.
    a_evict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[19:4] != '0)) |-> full)
        else $error("eviction reported while a frame is free");

    // An accepted item keeps the input closed for the following cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input reopened straight after an accepted item");

endmodule

// ===== verif/tb.sv =====
module tb;
    import apru_pkg::*;

    localparam int FRAMES     = 8;
    localparam int RUN_ITEMS  = 384;
    localparam int CYCLE_CAP  = 400000;
    localparam int TAIL_WAIT  = 16;

    // What one access should produce
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [PG_W-1:0]   evicted;
    } outcome_t;

    // Tracks the frame table and queues the outcome of every accepted access
    class page_tracker;
        logic [PG_W-1:0]  pages [FRAMES];
        logic [AGE_W-1:0] ages  [FRAMES];
        logic             refd  [FRAMES];
        int               filled;
        logic [TS_W-1:0]  prev_ts;
        outcome_t         due [$];
        int               errors;
        int               checked;

        function new();
            for (int j = 0; j < FRAMES; j++) begin
                pages[j] = '0;
                ages[j]  = '0;
                refd[j]  = 1'b0;
            end
            filled  = 0;
            prev_ts = '0;
            errors  = 0;
            checked = 0;
        endfunction

        task report(input string msg);
            $display("tb: mismatch at result %0d: %s", checked, msg);
            errors++;
        endtask

        function int pending();
            return due.size();
        endfunction

        // Ages the table on a new time stamp, then looks up, fills or evicts
        function void note_access(input logic [TS_W-1:0] ts, input logic [PG_W-1:0] pg);
            outcome_t       res;
            int             slot;
            logic           hit;
            logic [PG_W-1:0] gone;
            hit  = 1'b0;
            slot = 0;
            gone = '0;
            if (ts != prev_ts) begin
                for (int j = 0; j < FRAMES; j++) begin
                    ages[j] = ages[j] >> 1;
                    refd[j] = 1'b0;
                end
            end
            // Only filled frames can hit, so page zero never matches an empty one
            for (int j = 0; j < filled; j++) begin
                if (!hit && pages[j] == pg) begin
                    hit  = 1'b1;
                    slot = j;
                end
            end
            if (!hit) begin
                if (filled < FRAMES) begin
                    slot = filled;
                    filled++;
                end else begin
                    // Youngest age loses; equal ages go to the smaller page number
                    slot = 0;
                    for (int j = 1; j < FRAMES; j++) begin
                        if (ages[j] < ages[slot] ||
                            (ages[j] == ages[slot] && pages[j] < pages[slot]))
                            slot = j;
                    end
                    gone = pages[slot];
                end
                pages[slot] = pg;
                ages[slot]  = '0;
            end
            refd[slot] = 1'b1;
            for (int j = 0; j < filled; j++) begin
                if (refd[j])
                    ages[j][AGE_TOP] = 1'b1;
            end
            prev_ts     = ts;
            res.hit     = hit;
            res.slot    = slot[SLOT_W-1:0];
            res.evicted = gone;
            due.push_back(res);
        endfunction

        // Compares one result item with the oldest outstanding outcome
        task check_result(input logic [M_DATA_W-1:0] data);
            outcome_t want;
            if (due.size() == 0) begin
                report($sformatf("unexpected result %h", data));
                return;
            end
            want = due.pop_front();
            if (data[0] !== want.hit)
                report($sformatf("hit %b, want %b", data[0], want.hit));
            if (data[SLOT_W:1] !== want.slot)
                report($sformatf("frame_slot %0d, want %0d", data[SLOT_W:1], want.slot));
            if (data[SLOT_W+PG_W:SLOT_W+1] !== want.evicted)
                report($sformatf("evicted_page %h, want %h",
                                 data[SLOT_W+PG_W:SLOT_W+1], want.evicted));
            checked++;
        endtask
    endclass

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;  // time_stamp[15:0], page[31:16]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;   // hit[0], frame_slot[3:1], evicted_page[19:4]

    page_tracker sb = new();
    int          send_idle = 0;
    int          take_idle = 0;
    int          cycles    = 0;

    aging_page_replacement_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Run guard
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Result side: check what was taken at this edge, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        m_tready <= ($urandom_range(99) >= take_idle);
    end

    // Offers one access, with an optional gap before it, and waits for acceptance
    task automatic send_access(input logic [TS_W-1:0] ts, input logic [PG_W-1:0] pg);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pg, ts};
        do @(posedge aclk); while (!s_tready);
        sb.note_access(ts, pg);
    endtask

    // Holds off the sender until every outstanding result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    initial begin
        logic [PG_W-1:0] pool [12];
        logic [TS_W-1:0] cur_ts;
        logic [PG_W-1:0] pg;
        int              r;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part
        send_idle = 18;
        take_idle = 77;
        // Page zero at time zero: no aging tick, then a hit on it
        send_access(16'h0000, 16'h0000);
        send_access(16'h0000, 16'h0000);
        send_access(16'h0001, 16'hFFFF);
        send_access(16'h0001, 16'h8000);
        send_access(16'h0002, 16'h0001);
        send_access(16'h0003, 16'h7FFF);
        send_access(16'hFFFF, 16'h5555);
        send_access(16'hFFFF, 16'hAAAA);
        send_access(16'h8000, 16'h1234);
        // Keep one page young while every other frame ages down to zero
        for (int k = 0; k < 9; k++)
            send_access(TS_W'(16'h0100 + k), 16'hFFFF);
        // Equal ages: page zero goes first, then page one
        send_access(16'h0200, 16'h4321);
        send_access(16'h0200, 16'h0002);
        send_access(16'h0000, 16'h4321);
        send_access(16'hFFFF, 16'hFFFF);

        // Random part: a small working set so hits and evictions both occur
        for (int k = 0; k < 12; k++)
            pool[k] = (k < 4) ? PG_W'(k) : PG_W'($urandom_range(0, 65535));
        cur_ts = 16'h0300;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 18 : (phase == 1) ? 77 : 0;
            take_idle = (phase == 0) ? 77 : (phase == 1) ? 18 : 0;
            for (int n = 0; n < RUN_ITEMS; n++) begin
                if (phase == 1 && n == RUN_ITEMS / 2)
                    drain_results();
                r = $urandom_range(99);
                if (r < 55)
                    cur_ts = cur_ts;
                else if (r < 90)
                    cur_ts = cur_ts + TS_W'(1);
                else
                    cur_ts = TS_W'($urandom_range(0, 65535));
                if ($urandom_range(99) < 5)
                    pool[$urandom_range(11)] = PG_W'($urandom_range(0, 65535));
                if ($urandom_range(99) < 85)
                    pg = pool[$urandom_range(11)];
                else
                    pg = PG_W'($urandom_range(0, 65535));
                send_access(cur_ts, pg);
            end
        end
        s_tvalid <= 1'b0;

        // Let the last results drain, then allow a short tail
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (TAIL_WAIT) @(posedge aclk);
        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
